/* src/oph_pkg.sv */
// ============================================================================
// oph_pkg - shared types and constants of the ordinal pattern histogram
// Opcodes, pipeline token, result record and the factorial table.
// ============================================================================
package oph_pkg;

    // default parameter values
    localparam int MAX_WINDOW_DEF  = 5;
    localparam int COUNT_WIDTH_DEF = 32;

    // fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int OPCODE_W = 2;
    localparam int BIN_W    = 7;
    localparam int LEN_W    = 3;
    localparam int REPORT_W = 32;

    // output queue depth, also the number of results that may be owed
    localparam int FIFO_DEPTH = 8;

    // window length register
    localparam logic [LEN_W-1:0] LEN_RESET = 3'd2;
    localparam logic [LEN_W-1:0] LEN_MIN   = 3'd2;

    // result kinds
    localparam logic RES_PATTERN = 1'b0;
    localparam logic RES_COUNT   = 1'b1;

    // n! for n = 0 .. 7
    localparam int unsigned FACT_TAB [8] = '{1, 1, 2, 6, 24, 120, 720, 5040};

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        TK_PUSH,
        TK_READ,
        TK_CLEAR
    } t_tok_kind;

    typedef enum logic [1:0] {
        FW_NONE,
        FW_WRITE,
        FW_CLEAR
    } t_fw_kind;

    // one transaction travelling down the pipeline
    typedef struct packed {
        logic             valid;
        t_tok_kind        kind;
        logic [LEN_W-1:0] len;
        logic [BIN_W-1:0] pc;
        logic             in_range;
    } t_token;

    typedef struct packed {
        logic                kind;
        logic [BIN_W-1:0]    pattern_code;
        logic [REPORT_W-1:0] count;
    } t_result;

    function automatic int unsigned fact(input int n);
        return FACT_TAB[n[2:0]];
    endfunction

endpackage

/* src/ordinal_pattern_histogram.sv */
// ============================================================================
// ordinal_pattern_histogram - ordinal pattern counter over a sample stream
// Sliding window of signed samples as a row of cells; each full-window push
// counts its Lehmer-coded ordinal pattern in a saturating histogram.
//
//   channel  direction  handshake                     payload
//   in       slave      i_in_valid / o_in_ready       i_opcode i_sample i_bin_index
//   out      master     o_out_valid / i_out_ready     o_kind o_pattern_code o_count
//   cfg      slave      i_cfg_valid / o_cfg_ready     i_cfg_window_length
//
// One transaction per clock while o_in_ready is high; order comparisons
// are made when a sample enters the cell row, so the coding pipeline never
// waits on the window. An accepted transaction passes the input token register,
// the coder rank and sum stages, the count memory read and update, and the output queue.
// o_in_ready drops only while FIFO_DEPTH results are owed to the output.
// Synchronous active-low reset; the histogram is empty at once through
// per-bin valid bits, with no clearing pass. o_cfg_ready is always high.
// ============================================================================
module ordinal_pattern_histogram import oph_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input transactions
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [OPCODE_W-1:0]        i_opcode,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [BIN_W-1:0]           i_bin_index,
    // results
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_kind,
    output logic [BIN_W-1:0]           o_pattern_code,
    output logic [REPORT_W-1:0]        o_count,
    // configuration
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [LEN_W-1:0]           i_cfg_window_length
);

    localparam int BINS   = fact(MAX_WINDOW);
    localparam int CODE_W = $clog2(BINS);
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int CRED_W = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W  = LEN_W + 1;

    logic [LEN_W-1:0]  r_wlen;
    logic [LEN_W-1:0]  len_eff;
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [FILL_W-1:0] fill_inc;
    logic [CRED_W-1:0] r_credit;
    logic [CRED_W-1:0] n_credit;
    t_token            r_s1_tok;
    t_token            n_tok;
    t_opcode           opcode;
    logic              accept;
    logic              shift;
    logic              owes_result;
    logic              pop;

    logic signed [SAMPLE_W-1:0] w_sample    [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] w_sample_in [MAX_WINDOW];
    logic [MAX_WINDOW-2:0]      w_gt        [MAX_WINDOW];
    logic [MAX_WINDOW-2:0]      w_gt_in     [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]      w_gt_new;
    logic [MAX_WINDOW-2:0]      w_gt_entry;

    t_token            w_tok2;
    logic [CODE_W-1:0] w_code2;
    logic              w_res_valid;
    t_result           w_res;
    t_result           w_out;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= LEN_RESET;
        end else if (i_cfg_valid) begin
            r_wlen <= i_cfg_window_length;
        end
    end

    // clamp the pattern length to the supported range
    always_comb begin
        priority if (r_wlen < LEN_MIN) begin
            len_eff = LEN_MIN;
        end else if (r_wlen > LEN_W'(MAX_WINDOW)) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = r_wlen;
        end
    end

    // input handshake and credit for owed results
    assign o_in_ready = (r_credit < CRED_W'(FIFO_DEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign opcode     = t_opcode'(i_opcode);
    assign fill_inc   = (r_fill == FILL_W'(MAX_WINDOW)) ? r_fill : r_fill + FILL_W'(1);

    // decode the accepted transaction into a pipeline token
    always_comb begin
        n_fill         = r_fill;
        shift          = 1'b0;
        n_tok.valid    = 1'b0;
        n_tok.kind     = TK_PUSH;
        n_tok.len      = len_eff;
        n_tok.pc       = i_bin_index;
        n_tok.in_range = (32'(i_bin_index) < 32'(BINS));
        if (accept) begin
            unique case (opcode)
                OP_PUSH: begin
                    shift  = 1'b1;
                    n_fill = fill_inc;
                    if (CMP_W'(fill_inc) >= CMP_W'(len_eff)) begin
                        n_tok.valid = 1'b1;
                    end
                end
                OP_READ: begin
                    n_tok.valid = 1'b1;
                    n_tok.kind  = TK_READ;
                end
                OP_CLEAR: begin
                    n_fill      = '0;
                    n_tok.valid = 1'b1;
                    n_tok.kind  = TK_CLEAR;
                end
                default: begin
                end
            endcase
        end
    end

    assign owes_result = n_tok.valid && (n_tok.kind != TK_CLEAR);
    assign pop         = o_out_valid && i_out_ready;
    assign n_credit    = r_credit + CRED_W'(owes_result) - CRED_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill         <= '0;
            r_credit       <= '0;
            r_s1_tok.valid <= 1'b0;
        end else begin
            r_fill         <= n_fill;
            r_credit       <= n_credit;
            r_s1_tok.valid <= n_tok.valid;
        end
        r_s1_tok.kind     <= n_tok.kind;
        r_s1_tok.len      <= n_tok.len;
        r_s1_tok.pc       <= n_tok.pc;
        r_s1_tok.in_range <= n_tok.in_range;
    end

    // neighbor wiring of the cell row, newest sample enters the top cell
    always_comb begin
        for (int d = 0; d < MAX_WINDOW - 1; d++) begin
            w_gt_entry[d] = w_gt_new[MAX_WINDOW-1-d];
        end
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (k == MAX_WINDOW - 1) begin
                w_sample_in[k] = i_sample;
                w_gt_in[k]     = w_gt_entry;
            end else begin
                w_sample_in[k] = w_sample[k+1];
                w_gt_in[k]     = w_gt[k+1];
            end
        end
    end

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        oph_cell #(
            .MAX_WINDOW (MAX_WINDOW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_shift      (shift),
            .i_new_sample (i_sample),
            .i_sample_in  (w_sample_in[k]),
            .i_gt_in      (w_gt_in[k]),
            .o_sample     (w_sample[k]),
            .o_gt         (w_gt[k]),
            .o_gt_new     (w_gt_new[k])
        );
    end

    // pattern coding
    oph_coder #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_coder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (r_s1_tok),
        .i_gt    (w_gt),
        .o_tok   (w_tok2),
        .o_code  (w_code2)
    );

    // histogram update and read
    oph_hist #(
        .MAX_WINDOW  (MAX_WINDOW),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (w_tok2),
        .i_code      (w_code2),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output queue
    oph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_data  (w_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (w_out)
    );

    assign o_kind         = w_out.kind;
    assign o_pattern_code = w_out.pattern_code;
    assign o_count        = w_out.count;

    // checks
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRED_W'(FIFO_DEPTH))
        else $error("owed result count beyond queue depth");

    a_result_credited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (r_credit != '0))
        else $error("result produced without an owed credit");

    a_push_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_tok.valid && (r_s1_tok.kind == TK_PUSH))
            |-> (CMP_W'(r_fill) >= CMP_W'(r_s1_tok.len)))
        else $error("pattern coded from a window that is not full");

endmodule

/* src/oph_cell.sv */
// ============================================================================
// oph_cell - one window position
// Holds a sample and the order bits against its older neighbors, and passes
// both to the next older cell on a push.
// ============================================================================
module oph_cell import oph_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic signed [SAMPLE_W-1:0] i_new_sample,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [MAX_WINDOW-2:0]      i_gt_in,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic [MAX_WINDOW-2:0]      o_gt,
    output logic                       o_gt_new
);

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] n_sample;
    // bit d: the sample d+1 places older is strictly greater than this one
    logic [MAX_WINDOW-2:0]      r_gt;
    logic [MAX_WINDOW-2:0]      n_gt;

    // take the neighbor's contents on a push
    always_comb begin
        n_sample = r_sample;
        n_gt     = r_gt;
        if (i_shift) begin
            n_sample = i_sample_in;
            n_gt     = i_gt_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_gt     <= n_gt;
    end

    // compare the held sample against the one being pushed
    assign o_gt_new = (r_sample > i_new_sample);
    assign o_sample = r_sample;
    assign o_gt     = r_gt;

endmodule

/* src/oph_coder.sv */
// ============================================================================
// oph_coder - pattern coding pipeline
// Stage one counts ranks and inversions from the cell order bits, stage two
// sums the factorial-weighted digits into the Lehmer code.
// ============================================================================
module oph_coder import oph_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_token                  i_tok,
    input  logic [MAX_WINDOW-2:0]   i_gt [MAX_WINDOW],
    output t_token                  o_tok,
    output logic [$clog2(fact(MAX_WINDOW))-1:0] o_code
);

    localparam int BINS   = fact(MAX_WINDOW);
    localparam int CODE_W = $clog2(BINS);
    localparam int RW     = $clog2(MAX_WINDOW);
    localparam int CMP_W  = LEN_W + 1;

    logic                act    [MAX_WINDOW];
    logic [RW-1:0]       n_c    [MAX_WINDOW];
    logic [RW-1:0]       n_rank [MAX_WINDOW];
    logic [LEN_W-1:0]    n_w    [MAX_WINDOW];
    logic [RW-1:0]       r_c    [MAX_WINDOW];
    logic [LEN_W-1:0]    r_w    [MAX_WINDOW];
    t_token              r_tok1;
    t_token              r_tok2;
    t_token              n_tok2;
    logic [CODE_W-1:0]   n_sum;
    logic [CODE_W-1:0]   n_code;
    logic [CODE_W-1:0]   r_code;
    logic [CODE_W+BIN_W-1:0] bin_ext;
    logic [CODE_W+BIN_W-1:0] sum_ext;

    // positions inside the current pattern length
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            act[i] = ({1'b0, i_tok.len} + CMP_W'(i)) >= CMP_W'(MAX_WINDOW);
        end
    end

    // rank and count of greater earlier samples, per position
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            n_c[i]    = '0;
            n_rank[i] = '0;
            for (int j = 0; j < i; j++) begin
                if (act[j]) begin
                    if (i_gt[i][i-1-j]) begin
                        n_c[i] = n_c[i] + RW'(1);
                    end else begin
                        n_rank[i] = n_rank[i] + RW'(1);
                    end
                end
            end
            for (int j = i + 1; j < MAX_WINDOW; j++) begin
                if (i_gt[j][j-1-i]) begin
                    n_rank[i] = n_rank[i] + RW'(1);
                end
            end
            // digit weight index is the number of samples ranked above
            n_w[i] = i_tok.len - LEN_W'(1) - LEN_W'(n_rank[i]);
            if (!act[i]) begin
                n_c[i] = '0;
                n_w[i] = '0;
            end
        end
    end

    // stage one registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok1.valid <= 1'b0;
        end else begin
            r_tok1.valid <= i_tok.valid;
        end
        r_tok1.kind     <= i_tok.kind;
        r_tok1.len      <= i_tok.len;
        r_tok1.pc       <= i_tok.pc;
        r_tok1.in_range <= i_tok.in_range;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            r_c[i] <= n_c[i];
            r_w[i] <= n_w[i];
        end
    end

    // weighted digit sum
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            n_sum = n_sum + CODE_W'(r_c[i]) * CODE_W'(FACT_TAB[r_w[i]]);
        end
    end

    assign bin_ext = {{CODE_W{1'b0}}, r_tok1.pc};
    assign sum_ext = {{BIN_W{1'b0}}, n_sum};

    // a read carries its bin, a push its fresh code
    always_comb begin
        n_tok2 = r_tok1;
        n_code = n_sum;
        if (r_tok1.kind == TK_READ) begin
            n_code = bin_ext[CODE_W-1:0];
        end else begin
            n_tok2.pc = sum_ext[BIN_W-1:0];
        end
    end

    // stage two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok2.valid <= 1'b0;
        end else begin
            r_tok2.valid <= n_tok2.valid;
        end
        r_tok2.kind     <= n_tok2.kind;
        r_tok2.len      <= n_tok2.len;
        r_tok2.pc       <= n_tok2.pc;
        r_tok2.in_range <= n_tok2.in_range;
        r_code          <= n_code;
    end

    assign o_tok  = r_tok2;
    assign o_code = r_code;

endmodule

/* src/oph_hist.sv */
// ============================================================================
// oph_hist - pattern count store
// Count memory with per-bin valid bits, registered read, one-deep write
// forwarding and saturating update.
// ============================================================================
module oph_hist import oph_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_token                  i_tok,
    input  logic [$clog2(fact(MAX_WINDOW))-1:0] i_code,
    output logic                    o_res_valid,
    output t_result                 o_res
);

    localparam int BINS   = fact(MAX_WINDOW);
    localparam int CODE_W = $clog2(BINS);

    logic [COUNT_WIDTH-1:0] r_mem [BINS];
    logic [BINS-1:0]        r_vbit;
    t_token                 r_tok;
    logic [CODE_W-1:0]      r_code;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vbit;
    t_fw_kind               r_fw_kind;
    t_fw_kind               n_fw_kind;
    logic [CODE_W-1:0]      r_fw_code;
    logic [COUNT_WIDTH-1:0] r_fw_cnt;
    logic [COUNT_WIDTH-1:0] old_cnt;
    logic [COUNT_WIDTH-1:0] bumped;
    logic [COUNT_WIDTH-1:0] value;
    logic [COUNT_WIDTH+REPORT_W-1:0] value_ext;
    logic                   do_write;
    logic                   do_clear;

    // registered read of count and valid bit, stage token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_rd_data <= r_mem[i_code];
        r_rd_vbit <= r_vbit[i_code];
        r_code    <= i_code;
        r_tok.kind     <= i_tok.kind;
        r_tok.len      <= i_tok.len;
        r_tok.pc       <= i_tok.pc;
        r_tok.in_range <= i_tok.in_range;
    end

    assign do_write = r_tok.valid && (r_tok.kind == TK_PUSH);
    assign do_clear = r_tok.valid && (r_tok.kind == TK_CLEAR);

    // current count, with the update made at the edge of the read
    always_comb begin
        priority if (r_fw_kind == FW_CLEAR) begin
            old_cnt = '0;
        end else if ((r_fw_kind == FW_WRITE) && (r_fw_code == r_code)) begin
            old_cnt = r_fw_cnt;
        end else if (r_rd_vbit) begin
            old_cnt = r_rd_data;
        end else begin
            old_cnt = '0;
        end
        bumped = (&old_cnt) ? old_cnt : old_cnt + COUNT_WIDTH'(1);
    end

    // count write
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_code] <= bumped;
        end
        r_fw_code <= r_code;
        r_fw_cnt  <= bumped;
    end

    always_comb begin
        n_fw_kind = FW_NONE;
        if (do_clear) begin
            n_fw_kind = FW_CLEAR;
        end else if (do_write) begin
            n_fw_kind = FW_WRITE;
        end
    end

    // control: valid bits and forwarding record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit      <= '0;
            r_fw_kind   <= FW_NONE;
        end else begin
            r_fw_kind   <= n_fw_kind;
            if (do_clear) begin
                r_vbit <= '0;
            end else if (do_write) begin
                r_vbit[r_code] <= 1'b1;
            end
        end
    end

    // result value and report saturation
    always_comb begin
        if (r_tok.kind == TK_PUSH) begin
            value = bumped;
        end else if (r_tok.in_range) begin
            value = old_cnt;
        end else begin
            value = '0;
        end
    end

    assign value_ext = {{REPORT_W{1'b0}}, value};

    assign o_res_valid        = r_tok.valid && (r_tok.kind != TK_CLEAR);
    assign o_res.kind         = (r_tok.kind == TK_READ) ? RES_COUNT : RES_PATTERN;
    assign o_res.pattern_code = r_tok.pc;
    assign o_res.count        = (|value_ext[COUNT_WIDTH+REPORT_W-1:REPORT_W])
                                ? {REPORT_W{1'b1}} : value_ext[REPORT_W-1:0];

endmodule

/* src/oph_fifo.sv */
// ============================================================================
// oph_fifo - result queue
// Small register queue between the pipeline and the output channel.
// ============================================================================
module oph_fifo import oph_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_data,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result          r_buf [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt + CNT_W'(i_wr) - CNT_W'(pop);
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* verif/testbench.sv */
// ============================================================================
// testbench - regression for the ordinal pattern histogram
// Pushes, reads and clears flow in over the input channel while a built-in
// predictor tracks the window, the fill level and the pattern counts. Every
// result is checked field by field in order. Random gaps and stalls hit
// both channels, one long output hold-off fills the block, and the window
// length register is stepped through every value between phases.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
    import oph_pkg::*;

    localparam int NUM_BINS      = FACT_TAB[MAX_WINDOW_DEF];
    localparam int IDLE_PCT      = 35;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 10;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int LIMIT_CYCLES  = 100000;
    localparam int PHASE_ITEMS   = 95;

    // opcode the block must ignore
    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

    // window lengths visited by the random phases, out-of-range values included
    localparam logic [LEN_W-1:0] PHASE_LENGTHS [8] =
        '{3'd5, 3'd0, 3'd7, 3'd3, 3'd1, 3'd6, 3'd4, 3'd2};

    logic                       i_clk;
    logic                       i_rst_n             = 1'b0;
    logic                       i_in_valid          = 1'b0;
    logic                       o_in_ready;
    logic [OPCODE_W-1:0]        i_opcode            = '0;
    logic signed [SAMPLE_W-1:0] i_sample            = '0;
    logic [BIN_W-1:0]           i_bin_index         = '0;
    logic                       o_out_valid;
    logic                       i_out_ready         = 1'b0;
    logic                       o_kind;
    logic [BIN_W-1:0]           o_pattern_code;
    logic [REPORT_W-1:0]        o_count;
    logic                       i_cfg_valid         = 1'b0;
    logic                       o_cfg_ready;
    logic [LEN_W-1:0]           i_cfg_window_length = '0;

    // run control
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    bit          gaps_on     = 1'b1;
    bit          stalls_on   = 1'b1;
    logic        hold_req    = 1'b0;

    // predictor state
    logic signed [SAMPLE_W-1:0] model_window [MAX_WINDOW_DEF];
    int unsigned                model_fill;
    logic [REPORT_W-1:0]        model_bins [NUM_BINS];
    logic [LEN_W-1:0]           model_length;
    t_result                    owed_results [$];

    ordinal_pattern_histogram uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_sample            (i_sample),
        .i_bin_index         (i_bin_index),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_pattern_code      (o_pattern_code),
        .o_count             (o_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_window_length (i_cfg_window_length)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // register value clamped to the supported window lengths
    function automatic int unsigned model_eff_length();
        if (model_length < LEN_MIN)
            return int'(LEN_MIN);
        if (model_length > MAX_WINDOW_DEF)
            return MAX_WINDOW_DEF;
        return int'(model_length);
    endfunction

    // Lehmer code of the argsort of the newest len samples, ties by position
    function automatic logic [BIN_W-1:0] ordinal_code(input int unsigned len);
        int unsigned base;
        int unsigned rank;
        int unsigned inversions;
        int unsigned code;
        int unsigned order [MAX_WINDOW_DEF];
        base = MAX_WINDOW_DEF - len;
        code = 0;
        for (int i = 0; i < len; i++) begin
            rank = 0;
            for (int j = 0; j < len; j++)
                if (model_window[base+j] < model_window[base+i] ||
                    (model_window[base+j] == model_window[base+i] && j < i))
                    rank++;
            order[rank] = i;
        end
        for (int i = 0; i < len; i++) begin
            inversions = 0;
            for (int j = i + 1; j < len; j++)
                if (order[j] < order[i])
                    inversions++;
            code += inversions * FACT_TAB[len-1-i];
        end
        return code[BIN_W-1:0];
    endfunction

    function automatic void model_clear();
        foreach (model_window[i])
            model_window[i] = '0;
        foreach (model_bins[i])
            model_bins[i] = '0;
        model_fill = 0;
    endfunction

    // apply one accepted transaction and queue the result it owes
    function automatic void update_histogram_model(input logic [OPCODE_W-1:0] op,
                                                   input logic signed [SAMPLE_W-1:0] sample,
                                                   input logic [BIN_W-1:0] bin);
        t_result     res;
        int unsigned len;
        logic [BIN_W-1:0] code;
        case (op)
            OP_PUSH: begin
                for (int i = 0; i < MAX_WINDOW_DEF - 1; i++)
                    model_window[i] = model_window[i+1];
                model_window[MAX_WINDOW_DEF-1] = sample;
                if (model_fill < MAX_WINDOW_DEF)
                    model_fill++;
                len = model_eff_length();
                if (model_fill >= len) begin
                    code = ordinal_code(len);
                    if (model_bins[code] != '1)
                        model_bins[code] = model_bins[code] + 1'b1;
                    res.kind         = RES_PATTERN;
                    res.pattern_code = code;
                    res.count        = model_bins[code];
                    owed_results.push_back(res);
                end
            end
            OP_READ: begin
                res.kind         = RES_COUNT;
                res.pattern_code = bin;
                res.count        = (bin < NUM_BINS) ? model_bins[bin] : '0;
                owed_results.push_back(res);
            end
            OP_CLEAR: model_clear();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("cycle %0d: %s mismatch, got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        t_result want;
        if (owed_results.size() == 0) begin
            report_mismatch("unexpected result, kind", o_kind, 0);
        end else begin
            want = owed_results.pop_front();
            if (o_kind !== want.kind)
                report_mismatch("kind", o_kind, want.kind);
            if (o_pattern_code !== want.pattern_code)
                report_mismatch("pattern_code", o_pattern_code, want.pattern_code);
            if (o_count !== want.count)
                report_mismatch("count", o_count, want.count);
        end
    endtask

    // compare each result transaction against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_result();
    end

    // ------------------------------------------------------------------------
    // result receiver: random stalls and one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= !(stalls_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one transaction and wait for it to be taken
    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic signed [SAMPLE_W-1:0] sample,
                             input logic [BIN_W-1:0] bin);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_sample    <= sample;
        i_bin_index <= bin;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        update_histogram_model(op, sample, bin);
    endtask

    // stop sending and let every owed result and any push in flight settle
    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_length(input logic [LEN_W-1:0] value);
        wait_for_idle();
        i_cfg_valid         <= 1'b1;
        i_cfg_window_length <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        model_length = value;
        i_cfg_valid <= 1'b0;
    endtask

    // mix of small values for ties, extremes and full-range values
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return int'($urandom_range(6)) - 3;
        if (sel < 50) begin
            case ($urandom_range(3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // mostly bins reachable at the current length, sometimes any bin
    function automatic logic [BIN_W-1:0] pick_bin();
        if ($urandom_range(4) == 0)
            return BIN_W'($urandom_range(127));
        return BIN_W'($urandom_range(FACT_TAB[model_eff_length()] - 1));
    endfunction

    task automatic send_random_item(input int unsigned push_pct);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < push_pct)
            send_item(OP_PUSH, pick_sample(), BIN_W'($urandom));
        else if (sel < 93)
            send_item(OP_READ, SAMPLE_W'($urandom), pick_bin());
        else if (sel < 97)
            send_item(OP_RESERVED, SAMPLE_W'($urandom), BIN_W'($urandom));
        else
            send_item(OP_CLEAR, SAMPLE_W'($urandom), BIN_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty histogram after reset, including bins past the last pattern
    task automatic test_reset_reads();
        send_item(OP_READ, 32'sh0, 7'd0);
        send_item(OP_READ, 32'sh0, 7'd119);
        send_item(OP_READ, 32'sh0, 7'd120);
        send_item(OP_READ, 32'sh0, 7'd127);
    endtask

    // window filling at length two, sample extremes and equal samples
    task automatic test_fill_and_ties();
        send_item(OP_PUSH, 32'sh7FFF_FFFF, 7'd0);
        send_item(OP_PUSH, 32'sh8000_0000, 7'd0);
        send_item(OP_PUSH, 32'sh8000_0000, 7'd0);
        send_item(OP_PUSH, 32'sh0000_0000, 7'd0);
        send_item(OP_PUSH, 32'shFFFF_FFFF, 7'd0);
        send_item(OP_READ, 32'sh0, 7'd0);
        send_item(OP_READ, 32'sh0, 7'd1);
    endtask

    // ignored opcode, clear, then refill from an empty window
    task automatic test_clear_and_ignored();
        send_item(OP_RESERVED, 32'sh7FFF_FFFF, 7'h7F);
        send_item(OP_READ, 32'sh0, 7'd0);
        send_item(OP_CLEAR, 32'shFFFF_FFFF, 7'h7F);
        send_item(OP_READ, 32'sh0, 7'd0);
        send_item(OP_PUSH, 32'sh0000_0005, 7'd0);
        send_item(OP_PUSH, 32'sh0000_0009, 7'd0);
        send_item(OP_PUSH, 32'sh0000_0001, 7'd0);
        send_item(OP_READ, 32'sh0, 7'd0);
    endtask

    // no gaps and no stalls for a long stretch
    task automatic test_back_to_back();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (150) send_random_item(75);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // output held off while the sender keeps offering, so the input stalls
    task automatic test_output_hold();
        gaps_on  = 1'b0;
        hold_req <= 1'b1;
        repeat (40) send_random_item(50);
        gaps_on  = 1'b1;
    endtask

    // random traffic at every register value, window kept across changes
    task automatic test_random_lengths();
        foreach (PHASE_LENGTHS[p]) begin
            write_window_length(PHASE_LENGTHS[p]);
            repeat (PHASE_ITEMS) send_random_item(70);
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned waited;
        model_clear();
        model_length = LEN_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_reads();
        test_fill_and_ties();
        test_clear_and_ignored();
        test_back_to_back();
        test_output_hold();
        test_random_lengths();

        // drain, bounded so leftovers are reported rather than hung on
        i_in_valid <= 1'b0;
        for (waited = 0; owed_results.size() != 0 && waited < DRAIN_LIMIT; waited++)
            @(posedge i_clk);
        if (owed_results.size() != 0)
            report_mismatch("results never delivered, count", 0, owed_results.size());
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("ordinal_pattern_histogram regression: pass");
        else
            $display("ordinal_pattern_histogram regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("ordinal_pattern_histogram regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
src/oph_pkg.sv
src/oph_cell.sv
src/oph_coder.sv
src/oph_hist.sv
src/oph_fifo.sv
src/ordinal_pattern_histogram.sv
verif/testbench.sv
